FILE: sv/dwhc_pkg.sv
// Shared constants and types for the dual window hit counter.
`default_nettype none
package dwhc_pkg;
    localparam int LONG_WINDOW  = 3600;
    localparam int SHORT_WINDOW = 10;
    localparam int CNT_W        = 16;
    localparam int IDX_W        = $clog2(LONG_WINDOW);
    localparam int SHORT_BACK   = SHORT_WINDOW % LONG_WINDOW;
    localparam int SSUM_W       = 20;
    localparam int LSUM_W       = 28;
    localparam int PER_W        = 16;
    localparam int IN_DATA_W    = 16;
    localparam int OUT_DATA_W   = SSUM_W + LSUM_W;
    localparam int OUT_USER_W   = 2;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 16;

    localparam logic [PER_W-1:0] SHORT_PERIOD_RST = PER_W'(10);
    localparam logic [PER_W-1:0] LONG_PERIOD_RST  = PER_W'(30);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SHORT_PERIOD = 1'b0,
        CFG_LONG_PERIOD  = 1'b1
    } t_cfg_idx;
endpackage
`default_nettype wire

FILE: sv/dwhc_ram.sv
// Generic RAM: one write port, two registered read ports.
`default_nettype none
module dwhc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic      [WIDTH-1:0]         o_rdata_a,
    output logic      [WIDTH-1:0]         o_rdata_b
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata_a <= r_mem[i_raddr_a];
            o_rdata_b <= r_mem[i_raddr_b];
        end
    end
endmodule
`default_nettype wire

FILE: sv/dwhc_period.sv
// Report period counter: flags the tick on which the count reaches the period.
`default_nettype none
module dwhc_period (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_tick,
    input  wire logic [dwhc_pkg::PER_W-1:0] i_period,
    output logic                           o_due
);
    import dwhc_pkg::*;

    logic [PER_W-1:0] r_count;
    logic [PER_W-1:0] n_count;
    logic [PER_W-1:0] count_inc;

    always_comb begin
        count_inc = r_count + PER_W'(1);
        o_due     = (count_inc == i_period);
        n_count   = o_due ? '0 : count_inc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_tick) begin
            r_count <= n_count;
        end
    end
endmodule
`default_nettype wire

FILE: sv/dual_window_hit_counter_core.sv
// Dual window hit counter: top level with count ring and running sums.
//
// Input stream: one word per tick carrying that tick's hit count. Output
// stream: one word per input word with the short and long window sums and
// the two report flags. Configuration: write enable, register index and
// data; index 0 is the short report period, index 1 the long one. Write
// only while no word is in flight.
//
// An accepted word passes the middle stage register, then the output register.
// Throughput is one word per cycle while the receiver does not stall: the ring
// RAM reads both departing counts on accept and the write-back of one word
// overlaps the reads of the next, with forwarding where they hit the same entry.
//
// Reset empties the pipeline, clears both sums and period counters and
// restores the default periods. The ring is not swept: a write pointer
// and wrap flag mark entries not yet written, which read as zero, so
// words are accepted from the first cycle after reset.
//
// When the receiver stalls, the output register holds its word, one more
// word is taken into the middle stage, and then o_tready drops.
`default_nettype none
module dual_window_hit_counter_core (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_tvalid,
    output logic                                 o_tready,
    // [15:0] hits_this_second
    input  wire logic [dwhc_pkg::IN_DATA_W-1:0]  i_tdata,
    output logic                                 o_tvalid,
    input  wire logic                            i_tready,
    // [19:0] short_window_sum, [47:20] long_window_sum
    output logic      [dwhc_pkg::OUT_DATA_W-1:0] o_tdata,
    // [0] short_report_due, [1] long_report_due
    output logic      [dwhc_pkg::OUT_USER_W-1:0] o_tuser,
    input  wire logic                            i_cfg_we,
    input  wire logic [dwhc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [dwhc_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import dwhc_pkg::*;

    logic [PER_W-1:0]  r_short_period;
    logic [PER_W-1:0]  r_long_period;

    logic [IDX_W-1:0]  r_wr_idx;
    logic [IDX_W-1:0]  n_wr_idx;
    logic              r_wrapped;
    logic [IDX_W-1:0]  old_addr;

    logic              r_s1_valid;
    logic [CNT_W-1:0]  r_s1_hits;
    logic [IDX_W-1:0]  r_s1_pos;
    logic              r_s1_short_ok;
    logic              r_s1_long_ok;
    logic              r_s1_short_due;
    logic              r_s1_long_due;
    logic              r_fwd_short;
    logic              r_fwd_long;
    logic [CNT_W-1:0]  r_fwd_data;

    logic [SSUM_W-1:0] r_short_sum;
    logic [LSUM_W-1:0] r_long_sum;
    logic [SSUM_W-1:0] n_short_sum;
    logic [LSUM_W-1:0] n_long_sum;

    logic              r_out_valid;
    logic [SSUM_W-1:0] r_out_short;
    logic [LSUM_W-1:0] r_out_long;
    logic              r_out_short_due;
    logic              r_out_long_due;

    logic              in_go;
    logic              s1_go;
    logic [CNT_W-1:0]  in_hits;
    logic [CNT_W-1:0]  rd_short;
    logic [CNT_W-1:0]  rd_long;
    logic [CNT_W-1:0]  short_leaving;
    logic [CNT_W-1:0]  long_leaving;
    logic              short_due;
    logic              long_due;

    assign s1_go    = r_s1_valid && (!r_out_valid || i_tready);
    assign o_tready = !r_s1_valid || s1_go;
    assign in_go    = i_tvalid && o_tready;
    assign in_hits  = i_tdata[CNT_W-1:0];

    always_comb begin
        if (r_wr_idx >= IDX_W'(SHORT_BACK)) begin
            old_addr = r_wr_idx - IDX_W'(SHORT_BACK);
        end else begin
            old_addr = IDX_W'(LONG_WINDOW - SHORT_BACK) + r_wr_idx;
        end
        if (r_wr_idx == IDX_W'(LONG_WINDOW - 1)) begin
            n_wr_idx = '0;
        end else begin
            n_wr_idx = r_wr_idx + IDX_W'(1);
        end
    end

    dwhc_ram #(
        .WIDTH (CNT_W),
        .DEPTH (LONG_WINDOW)
    ) u_ring (
        .i_clk     (i_clk),
        .i_we      (s1_go),
        .i_waddr   (r_s1_pos),
        .i_wdata   (r_s1_hits),
        .i_re      (in_go),
        .i_raddr_a (old_addr),
        .i_raddr_b (r_wr_idx),
        .o_rdata_a (rd_short),
        .o_rdata_b (rd_long)
    );

    dwhc_period u_short_period (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tick   (in_go),
        .i_period (r_short_period),
        .o_due    (short_due)
    );

    dwhc_period u_long_period (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tick   (in_go),
        .i_period (r_long_period),
        .o_due    (long_due)
    );

    always_comb begin
        if (r_fwd_short) begin
            short_leaving = r_fwd_data;
        end else if (r_s1_short_ok) begin
            short_leaving = rd_short;
        end else begin
            short_leaving = '0;
        end
        if (r_fwd_long) begin
            long_leaving = r_fwd_data;
        end else if (r_s1_long_ok) begin
            long_leaving = rd_long;
        end else begin
            long_leaving = '0;
        end
        n_short_sum = r_short_sum + SSUM_W'(r_s1_hits) - SSUM_W'(short_leaving);
        n_long_sum  = r_long_sum + LSUM_W'(r_s1_hits) - LSUM_W'(long_leaving);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short_period <= SHORT_PERIOD_RST;
            r_long_period  <= LONG_PERIOD_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_SHORT_PERIOD: r_short_period <= i_cfg_data[PER_W-1:0];
                CFG_LONG_PERIOD:  r_long_period  <= i_cfg_data[PER_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_idx    <= '0;
            r_wrapped   <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_short_sum <= '0;
            r_long_sum  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_go) begin
                r_wr_idx <= n_wr_idx;
                if (r_wr_idx == IDX_W'(LONG_WINDOW - 1)) begin
                    r_wrapped <= 1'b1;
                end
                r_s1_valid <= 1'b1;
            end else if (s1_go) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_go) begin
                r_short_sum <= n_short_sum;
                r_long_sum  <= n_long_sum;
                r_out_valid <= 1'b1;
            end else if (i_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_go) begin
            r_s1_hits      <= in_hits;
            r_s1_pos       <= r_wr_idx;
            r_s1_short_ok  <= r_wrapped || ((SHORT_BACK != 0) &&
                                            (r_wr_idx >= IDX_W'(SHORT_BACK)));
            r_s1_long_ok   <= r_wrapped;
            r_s1_short_due <= short_due;
            r_s1_long_due  <= long_due;
            // write-back of the word ahead lands on the same edge as these reads
            r_fwd_short    <= s1_go && (r_s1_pos == old_addr);
            r_fwd_long     <= s1_go && (r_s1_pos == r_wr_idx);
            r_fwd_data     <= r_s1_hits;
        end
        if (s1_go) begin
            r_out_short     <= n_short_sum;
            r_out_long      <= n_long_sum;
            r_out_short_due <= r_s1_short_due;
            r_out_long_due  <= r_s1_long_due;
        end
    end

    assign o_tvalid = r_out_valid;
    assign o_tdata  = {r_out_long, r_out_short};
    assign o_tuser  = {r_out_long_due, r_out_short_due};
endmodule
`default_nettype wire

FILE: sv/dwhc_checker.sv
// Port-level checks for the dual window hit counter, bound to the top level.
`default_nettype none
module dwhc_checker (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            i_tvalid,
    input wire logic                            o_tready,
    input wire logic                            o_tvalid,
    input wire logic                            i_tready,
    input wire logic [dwhc_pkg::OUT_DATA_W-1:0] o_tdata,
    input wire logic [dwhc_pkg::OUT_USER_W-1:0] o_tuser
);
    import dwhc_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_tvalid && !i_tready) |=> (o_tvalid && $stable(o_tdata) && $stable(o_tuser)))
        else $error("output word changed while stalled");

    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_tready |-> o_tready)
        else $error("input blocked while output drains");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_tvalid && o_tready && i_tready) ##1 i_tready |=> o_tvalid)
        else $error("accepted word missing at output");

    a_short_le_long: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_tvalid |-> (LSUM_W'(o_tdata[SSUM_W-1:0]) <= o_tdata[OUT_DATA_W-1:SSUM_W]))
        else $error("short window sum exceeds long window sum");
endmodule

bind dual_window_hit_counter_core dwhc_checker u_dwhc_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_tvalid (i_tvalid),
    .o_tready (o_tready),
    .o_tvalid (o_tvalid),
    .i_tready (i_tready),
    .o_tdata  (o_tdata),
    .o_tuser  (o_tuser)
);
`default_nettype wire
